// ----- rtl/core/lrt_pkg.sv -----
`default_nettype none

package lrt_pkg;

  // Default sizing of the tracker.
  localparam int LRT_CAPACITY = 16;
  localparam int LRT_KEY_BITS = 32;

  // Widths of the request and response fields.
  localparam int LRT_OP_W     = 2;
  localparam int LRT_KEY_W    = 32;
  localparam int LRT_STATUS_W = 3;
  localparam int LRT_OCC_W    = 5;

  // Operation codes.
  localparam logic [LRT_OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [LRT_OP_W-1:0] OP_EVICT  = 2'd1;
  localparam logic [LRT_OP_W-1:0] OP_ERASE  = 2'd2;

  // Status codes.
  localparam logic [LRT_STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [LRT_STATUS_W-1:0] ST_REFRESHED = 3'd1;
  localparam logic [LRT_STATUS_W-1:0] ST_EVICTED   = 3'd2;
  localparam logic [LRT_STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [LRT_STATUS_W-1:0] ST_ERASED    = 3'd4;
  localparam logic [LRT_STATUS_W-1:0] ST_ABSENT    = 3'd5;
  localparam logic [LRT_STATUS_W-1:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic [LRT_OP_W-1:0]  operation;
    logic [LRT_KEY_W-1:0] key;
  } lrt_req_t;

  typedef struct packed {
    logic [LRT_STATUS_W-1:0] status;
    logic [LRT_KEY_W-1:0]    victim_key;
    logic [LRT_OCC_W-1:0]    occupancy;
  } lrt_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/lru_replacement_tracker_top.sv -----
// A request is captured in the request register, and its response is registered in the
// response register, where it is held while out_stall is high.
// Throughput: one request per cycle while the response is not stalled; every entry compares
// against the key in parallel and the whole ordered store shifts and writes in the same cycle.
// Reset (synchronous, active low) empties the tracker and clears both pipeline stages;
// the key store itself is not cleared, as only entries below the count are ever used.
`default_nettype none

module lru_replacement_tracker_top
  import lrt_pkg::*;
#(
  parameter int CAPACITY = LRT_CAPACITY,
  parameter int KEY_BITS = LRT_KEY_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire lrt_req_t in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lrt_rsp_t      out_rsp
);

  // Only the low KEY_BITS bits of the 32-bit key field take part, so the stored
  // width is the smaller of the two.
  localparam int SKW = (KEY_BITS < LRT_KEY_W) ? KEY_BITS : LRT_KEY_W;
  // Index of an entry, and the count which must also hold CAPACITY itself.
  localparam int CIW = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);

  // Request stage.
  logic                s1_valid_r;
  logic [LRT_OP_W-1:0] s1_op_r;
  logic [SKW-1:0]      s1_key_r;

  // Response stage.
  logic     out_valid_r;
  lrt_rsp_t out_rsp_r;
  lrt_rsp_t rsp_nxt;

  // Ordered store: position 0 is the least recently used key.
  logic [SKW-1:0] keys_r   [CAPACITY];
  logic [SKW-1:0] keys_nxt [CAPACITY];
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic [CW-1:0]  count_dec;

  logic                advance;
  logic                s1_fire;
  logic [CAPACITY-1:0] match;
  logic                hit;
  logic [CIW-1:0]      hit_pos;
  logic                shift_en;
  logic [CIW-1:0]      shift_from;
  logic                wr_en;
  logic [CIW-1:0]      wr_idx;

  // The response register moves whenever it is empty or being taken; the request
  // register is held only when its request cannot move on.
  assign advance   = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign count_dec = count_r - CW'(1);

  // Parallel compare of every live entry against the request key. Keys are kept
  // distinct, so at most one entry matches and its position can be formed by OR.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_r) && (keys_r[i] == s1_key_r);
      if (match[i]) begin
        hit_pos = hit_pos | CIW'(i);
      end
    end
    hit = |match;
  end

  // Operation decode: decide the response, whether the store closes a gap from some
  // position towards the least recent end, and where the request key is written.
  always_comb begin
    rsp_nxt            = '0;
    rsp_nxt.status     = ST_ABSENT;
    count_nxt          = count_r;
    shift_en           = 1'b0;
    shift_from         = '0;
    wr_en              = 1'b0;
    wr_idx             = '0;
    unique case (s1_op_r)
      OP_INSERT: begin
        if (hit) begin
          // A touched key leaves its place and rejoins at the most recent end.
          rsp_nxt.status = ST_REFRESHED;
          shift_en       = 1'b1;
          shift_from     = hit_pos;
          wr_en          = 1'b1;
          wr_idx         = count_dec[CIW-1:0];
        end else if (count_r == CW'(CAPACITY)) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          rsp_nxt.status = ST_INSERTED;
          wr_en          = 1'b1;
          wr_idx         = count_r[CIW-1:0];
          count_nxt      = count_r + CW'(1);
        end
      end
      OP_EVICT: begin
        if (count_r == '0) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.status     = ST_EVICTED;
          rsp_nxt.victim_key = LRT_KEY_W'(keys_r[0]);
          shift_en           = 1'b1;
          count_nxt          = count_dec;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          rsp_nxt.status = ST_ERASED;
          shift_en       = 1'b1;
          shift_from     = hit_pos;
          count_nxt      = count_dec;
        end
      end
      default: begin
        rsp_nxt.status = ST_ABSENT;
      end
    endcase
    rsp_nxt.occupancy = LRT_OCC_W'(count_nxt);
  end

  // Each entry either keeps its key, takes its upper neighbour's, or takes the new key.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keys_nxt[i] = keys_r[i];
      if (shift_en && (CIW'(i) >= shift_from) && (i < CAPACITY - 1)) begin
        keys_nxt[i] = keys_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
      if (wr_en && (CIW'(i) == wr_idx)) begin
        keys_nxt[i] = s1_key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op_r  <= in_req.operation;
      s1_key_r <= in_req.key[SKW-1:0];
    end
    if (s1_fire) begin
      out_rsp_r <= rsp_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        keys_r[i] <= keys_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lrt_checker.sv -----
`default_nettype none

module lrt_checker
  import lrt_pkg::*;
#(
  parameter int CAPACITY = LRT_CAPACITY
) (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lrt_rsp_t out_rsp
);

  // Only an eviction returns a key.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != ST_EVICTED)) |-> (out_rsp.victim_key == '0))
    else $error("victim key set on a response that is not an eviction");

  // A rejected insert means the tracker is exactly full.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == ST_FULL)) |-> (out_rsp.occupancy == LRT_OCC_W'(CAPACITY)))
    else $error("full status with occupancy other than capacity");

  // An empty eviction leaves nothing tracked.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == ST_EMPTY)) |-> (out_rsp.occupancy == '0))
    else $error("empty status with non-zero occupancy");

  // A stalled response is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
    else $error("response changed while stalled");

endmodule

bind lru_replacement_tracker_top lrt_checker #(.CAPACITY(CAPACITY)) u_lrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

`default_nettype wire
